@@ rtl/core/stepper_trapezoid_ramp_core_defines.svh @@
// assertion macros shared by the stepper ramp rtl
`ifndef STEPPER_TRAPEZOID_RAMP_CORE_DEFINES_SVH
`define STEPPER_TRAPEZOID_RAMP_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define STPR_ASSERT_IMP(name, clk_s, rst_s, pre, post) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
        else $error("stpr check failed");

// next-cycle implication, disabled during reset
`define STPR_ASSERT_NXT(name, clk_s, rst_s, pre, post) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
        else $error("stpr check failed");

`endif

@@ rtl/core/stpr_pkg.sv @@
// shared constants, codes and types of the stepper ramp generator
package stpr_pkg;

    // default widths of position and step rate
    localparam int POS_WIDTH_DEF  = 31;
    localparam int RATE_WIDTH_DEF = 20;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_RATE_W = 20;

    // shared divider width
    localparam int DIV_W = 32;

    // command codes
    localparam int FUNC_W = 2;
    localparam logic [FUNC_W-1:0] FUNC_MOVE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd2;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLOCK_HZ   = 2'd0,
        REG_MIN_RATE   = 2'd1,
        REG_MAX_RATE   = 2'd2,
        REG_ACCEL_STEP = 2'd3
    } cfg_idx_t;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] CLOCK_HZ_RST   = 32'd1000000;
    localparam logic [CFG_RATE_W-1:0] MIN_RATE_RST   = 20'd100;
    localparam logic [CFG_RATE_W-1:0] MAX_RATE_RST   = 20'd2000;
    localparam logic [CFG_RATE_W-1:0] ACCEL_STEP_RST = 20'd10;

    // divider request and status
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ rtl/core/stpr_if.sv @@
// valid/ready channels of the stepper ramp generator

// command channel
interface stpr_cmd_if #(
    parameter int POS_WIDTH = stpr_pkg::POS_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic [stpr_pkg::FUNC_W-1:0]       func;
    logic signed [POS_WIDTH-1:0]       value;

    modport source (output valid, func, value, input ready);
    modport sink   (input valid, func, value, output ready);
endinterface

// result channel
interface stpr_res_if #(
    parameter int POS_WIDTH = stpr_pkg::POS_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic [stpr_pkg::DIV_W-1:0]        reload_value;
    logic                              reload_written;
    logic                              direction_reverse;
    logic                              running;
    logic                              stopped_now;
    logic signed [POS_WIDTH-1:0]       position;

    modport source (output valid, reload_value, reload_written, direction_reverse,
                    running, stopped_now, position, input ready);
    modport sink   (input valid, reload_value, reload_written, direction_reverse,
                    running, stopped_now, position, output ready);
endinterface

// configuration write channel
interface stpr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [stpr_pkg::CFG_IDX_W-1:0]    index;
    logic [stpr_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/stpr_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
`include "stepper_trapezoid_ramp_core_defines.svh"

module stpr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  stpr_pkg::div_req_t            req,
    output stpr_pkg::div_stat_t           stat,
    output logic [stpr_pkg::DIV_W-1:0]    quotient
);

    localparam int DW    = stpr_pkg::DIV_W;
    localparam int CNT_W = $clog2(DW);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    dsr_reg, dsr_next;

    logic [DW:0]      trial;
    logic [DW:0]      trial_diff;
    logic             fits;

    // one trial subtraction
    always_comb
    begin
        trial      = {rem_reg, quo_reg[DW-1]};
        trial_diff = trial - {1'b0, dsr_reg};
        fits       = trial >= {1'b0, dsr_reg};
    end

    // sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DW - 1);
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial_diff[DW-1:0] : trial[DW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

    // checks
    `STPR_ASSERT_IMP(a_start_when_free, clk, rst_n, req.start, !busy_reg)
    `STPR_ASSERT_NXT(a_last_bit_done, clk, rst_n, busy_reg && cnt_reg == '0, done_reg && !busy_reg)
    `STPR_ASSERT_IMP(a_done_not_busy, clk, rst_n, done_reg, !busy_reg)

endmodule

@@ rtl/core/stepper_trapezoid_ramp_core.sv @@
// top level of the trapezoidal stepper ramp generator
//
//  channel | dir | handshake    | beat contents
//  --------+-----+--------------+-------------------------------------------------
//  cfg     | in  | valid/ready  | index, data (register write, always ready)
//  cmd     | in  | valid/ready  | func, value
//  res     | out | valid/ready  | reload_value, reload_written, direction_reverse,
//          |     |              | running, stopped_now, position
//
//  a tick that writes a reload for a nonzero rate waits in S_RELOAD on the serial
//  divider, then S_EMIT loads the result; a move with a nonempty ramp gets the
//  ramp length from the same divider in S_RAMP, then the split in S_SPLIT
//  cmd is ready only while the sequencer is idle; one command is in flight at a time
//  a finished result sits in the output register while the next command is taken
//  reset loads the reset values and clears control and motion state; no clearing pass
`include "stepper_trapezoid_ramp_core_defines.svh"

module stepper_trapezoid_ramp_core #(
    parameter int POS_WIDTH  = stpr_pkg::POS_WIDTH_DEF,
    parameter int RATE_WIDTH = stpr_pkg::RATE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    stpr_cfg_if.sink    cfg,
    stpr_cmd_if.sink    cmd,
    stpr_res_if.source  res
);

    localparam int P  = POS_WIDTH;
    localparam int R  = RATE_WIDTH;
    localparam int CR = stpr_pkg::CFG_RATE_W;
    localparam int DW = stpr_pkg::DIV_W;
    localparam int SW = ((R > CR) ? R : CR) + 1;
    localparam int CW = ((P > CR + 1) ? P : CR + 1) + 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RAMP   = 5'b00010,
        S_SPLIT  = 5'b00100,
        S_RELOAD = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t             state_reg, state_next;

    // configuration registers
    logic [DW-1:0]      clock_hz_reg, clock_hz_next;
    logic [CR-1:0]      min_rate_reg, min_rate_next;
    logic [CR-1:0]      max_rate_reg, max_rate_next;
    logic [CR-1:0]      accel_reg, accel_next;

    // motion state
    logic [P-1:0]       cur_pos_reg, cur_pos_next;
    logic [P-1:0]       target_reg, target_next;
    logic               dir_reg, dir_next;
    logic [R-1:0]       rate_reg, rate_next;
    logic [P-1:0]       accel_left_reg, accel_left_next;
    logic [P-1:0]       decel_left_reg, decel_left_next;
    logic               running_reg, running_next;

    // per-command working values
    logic [P-1:0]       dist_reg, dist_next;
    logic [CR-1:0]      ramp_reg, ramp_next;
    logic [DW-1:0]      reload_reg, reload_next;
    logic               written_reg, written_next;
    logic               stopped_reg, stopped_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [DW-1:0]      out_reload_reg, out_reload_next;
    logic               out_written_reg, out_written_next;
    logic               out_dir_reg, out_dir_next;
    logic               out_running_reg, out_running_next;
    logic               out_stopped_reg, out_stopped_next;
    logic [P-1:0]       out_pos_reg, out_pos_next;

    logic               cmd_acc;
    logic               out_load;
    logic               move_go;
    logic               ramp_en;
    logic signed [P:0]  diff;
    logic [P-1:0]       move_dist;
    logic [P-1:0]       pos_step;
    logic               pos_hit;
    logic [SW-1:0]      rate_inc;
    logic [R-1:0]       rate_up;
    logic [R-1:0]       rate_dn;
    logic [R-1:0]       tick_rate;
    logic               tick_write;
    logic [CW-1:0]      ramp_twice;

    stpr_pkg::div_req_t  div_req;
    stpr_pkg::div_stat_t div_stat;
    logic [DW-1:0]       div_quo;

    // shared divider
    stpr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign cmd_acc   = cmd.valid && cmd.ready;
    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || res.ready);

    // move arithmetic: signed distance, direction, ramp availability
    always_comb
    begin
        move_go   = cmd.value != cur_pos_reg;
        diff      = $signed({cmd.value[P-1], cmd.value}) -
                    $signed({cur_pos_reg[P-1], cur_pos_reg});
        move_dist = diff[P] ? P'(-diff) : diff[P-1:0];
        ramp_en   = (accel_reg != '0) && (max_rate_reg > min_rate_reg);
    end

    // tick arithmetic: position step and rate ramp
    always_comb
    begin
        pos_step   = dir_reg ? (cur_pos_reg - 1'b1) : (cur_pos_reg + 1'b1);
        pos_hit    = pos_step == target_reg;
        rate_inc   = SW'(rate_reg) + SW'(accel_reg);
        rate_up    = (rate_inc > SW'(max_rate_reg)) ? R'(max_rate_reg) : R'(rate_inc);
        rate_dn    = (SW'(rate_reg) < SW'(min_rate_reg) + SW'(accel_reg)) ?
                     R'(min_rate_reg) : R'(SW'(rate_reg) - SW'(accel_reg));
        tick_write = (accel_left_reg != '0) || (decel_left_reg != '0);
        tick_rate  = (accel_left_reg != '0) ? rate_up : rate_dn;
        ramp_twice = CW'(ramp_reg) << 1;
    end

    // divider launch on accept
    always_comb
    begin
        div_req.start = 1'b0;
        if (cmd_acc)
        begin
            if (cmd.func == stpr_pkg::FUNC_MOVE)
                div_req.start = move_go && ramp_en;
            else if (cmd.func == stpr_pkg::FUNC_TICK)
                div_req.start = running_reg && tick_write && (tick_rate != '0);
        end
        if (cmd.func == stpr_pkg::FUNC_MOVE)
        begin
            div_req.dividend = DW'(max_rate_reg - min_rate_reg);
            div_req.divisor  = DW'(accel_reg);
        end
        else
        begin
            div_req.dividend = clock_hz_reg;
            div_req.divisor  = DW'(tick_rate);
        end
    end

    // configuration writes
    always_comb
    begin
        clock_hz_next = clock_hz_reg;
        min_rate_next = min_rate_reg;
        max_rate_next = max_rate_reg;
        accel_next    = accel_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (stpr_pkg::cfg_idx_t'(cfg.index))
                stpr_pkg::REG_CLOCK_HZ:   clock_hz_next = cfg.data;
                stpr_pkg::REG_MIN_RATE:   min_rate_next = cfg.data[CR-1:0];
                stpr_pkg::REG_MAX_RATE:   max_rate_next = cfg.data[CR-1:0];
                stpr_pkg::REG_ACCEL_STEP: accel_next    = cfg.data[CR-1:0];
            endcase
        end
    end

    // command sequencer
    always_comb
    begin
        state_next      = state_reg;
        cur_pos_next    = cur_pos_reg;
        target_next     = target_reg;
        dir_next        = dir_reg;
        rate_next       = rate_reg;
        accel_left_next = accel_left_reg;
        decel_left_next = decel_left_reg;
        running_next    = running_reg;
        dist_next       = dist_reg;
        ramp_next       = ramp_reg;
        reload_next     = reload_reg;
        written_next    = written_reg;
        stopped_next    = stopped_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    reload_next  = '0;
                    written_next = 1'b0;
                    stopped_next = 1'b0;
                    state_next   = S_EMIT;
                    unique case (cmd.func)
                        stpr_pkg::FUNC_MOVE:
                        begin
                            if (move_go)
                            begin
                                target_next  = cmd.value;
                                dir_next     = diff[P];
                                rate_next    = R'(min_rate_reg);
                                dist_next    = move_dist;
                                running_next = 1'b1;
                                ramp_next    = '0;
                                state_next   = ramp_en ? S_RAMP : S_SPLIT;
                            end
                        end
                        stpr_pkg::FUNC_TICK:
                        begin
                            if (running_reg)
                            begin
                                cur_pos_next = pos_step;
                                if (pos_hit || !tick_write)
                                begin
                                    running_next = 1'b0;
                                    stopped_next = 1'b1;
                                end
                                if (tick_write)
                                begin
                                    rate_next    = tick_rate;
                                    written_next = 1'b1;
                                    if (accel_left_reg != '0)
                                        accel_left_next = accel_left_reg - 1'b1;
                                    else
                                        decel_left_next = decel_left_reg - 1'b1;
                                    if (tick_rate == '0)
                                        reload_next = '1;
                                    else
                                        state_next = S_RELOAD;
                                end
                            end
                        end
                        stpr_pkg::FUNC_SET:
                        begin
                            cur_pos_next = cmd.value;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_RAMP:
            begin
                if (div_stat.done)
                begin
                    ramp_next  = div_quo[CR-1:0];
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                // long move: full ramps; short move: half each way
                if (CW'(dist_reg) >= ramp_twice)
                begin
                    accel_left_next = P'(CW'(dist_reg) - CW'(ramp_reg));
                    decel_left_next = P'(ramp_reg);
                end
                else
                begin
                    accel_left_next = dist_reg >> 1;
                    decel_left_next = dist_reg >> 1;
                end
                state_next = S_EMIT;
            end
            S_RELOAD:
            begin
                if (div_stat.done)
                begin
                    reload_next = div_quo;
                    state_next  = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_reload_next  = out_reload_reg;
        out_written_next = out_written_reg;
        out_dir_next     = out_dir_reg;
        out_running_next = out_running_reg;
        out_stopped_next = out_stopped_reg;
        out_pos_next     = out_pos_reg;
        if (out_load)
        begin
            out_valid_next   = 1'b1;
            out_reload_next  = reload_reg;
            out_written_next = written_reg;
            out_dir_next     = dir_reg;
            out_running_next = running_reg;
            out_stopped_next = stopped_reg;
            out_pos_next     = cur_pos_reg;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control and motion state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            clock_hz_reg   <= stpr_pkg::CLOCK_HZ_RST;
            min_rate_reg   <= stpr_pkg::MIN_RATE_RST;
            max_rate_reg   <= stpr_pkg::MAX_RATE_RST;
            accel_reg      <= stpr_pkg::ACCEL_STEP_RST;
            cur_pos_reg    <= '0;
            target_reg     <= '0;
            dir_reg        <= 1'b0;
            rate_reg       <= '0;
            accel_left_reg <= '0;
            decel_left_reg <= '0;
            running_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clock_hz_reg   <= clock_hz_next;
            min_rate_reg   <= min_rate_next;
            max_rate_reg   <= max_rate_next;
            accel_reg      <= accel_next;
            cur_pos_reg    <= cur_pos_next;
            target_reg     <= target_next;
            dir_reg        <= dir_next;
            rate_reg       <= rate_next;
            accel_left_reg <= accel_left_next;
            decel_left_reg <= decel_left_next;
            running_reg    <= running_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // working values and result payload
    always_ff @(posedge clk)
    begin
        dist_reg        <= dist_next;
        ramp_reg        <= ramp_next;
        reload_reg      <= reload_next;
        written_reg     <= written_next;
        stopped_reg     <= stopped_next;
        out_reload_reg  <= out_reload_next;
        out_written_reg <= out_written_next;
        out_dir_reg     <= out_dir_next;
        out_running_reg <= out_running_next;
        out_stopped_reg <= out_stopped_next;
        out_pos_reg     <= out_pos_next;
    end

    assign res.valid             = out_valid_reg;
    assign res.reload_value      = out_reload_reg;
    assign res.reload_written    = out_written_reg;
    assign res.direction_reverse = out_dir_reg;
    assign res.running           = out_running_reg;
    assign res.stopped_now       = out_stopped_reg;
    assign res.position          = out_pos_reg;

    // checks
    `STPR_ASSERT_IMP(a_stop_not_running, clk, rst_n, out_valid_reg && out_stopped_reg, !out_running_reg)
    `STPR_ASSERT_IMP(a_reload_on_motion, clk, rst_n, out_valid_reg && out_written_reg, out_running_reg || out_stopped_reg)
    `STPR_ASSERT_IMP(a_div_owner, clk, rst_n, div_stat.busy, state_reg == S_RAMP || state_reg == S_RELOAD)
    `STPR_ASSERT_NXT(a_emit_holds, clk, rst_n, state_reg == S_EMIT && out_valid_reg && !res.ready, state_reg == S_EMIT)

endmodule

@@ test/stepper_trapezoid_ramp_core_test.sv @@
// testbench of the trapezoidal stepper ramp generator with its own ramp predictor
`timescale 1ns / 100ps

module stepper_trapezoid_ramp_core_test;

    // command code that the block ignores
    localparam logic [stpr_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // position extremes of the 31-bit signed range
    localparam logic [30:0] POS_MAX = 31'h3FFF_FFFF;
    localparam logic [30:0] POS_MIN = 31'h4000_0000;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 40;
    localparam int SHOWN_ERRORS = 10;

    // one predicted status beat
    typedef struct packed {
        logic [31:0] reload;
        logic        written;
        logic        reverse;
        logic        running;
        logic        stopped;
        logic [30:0] pos;
    } ramp_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    stpr_cfg_if cfg_ch ();
    stpr_cmd_if cmd_ch ();
    stpr_res_if res_ch ();

    stepper_trapezoid_ramp_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    always #2 clk = ~clk;

    // predictor copy of the registers
    logic [31:0] cfg_hz    = stpr_pkg::CLOCK_HZ_RST;
    logic [19:0] cfg_min   = stpr_pkg::MIN_RATE_RST;
    logic [19:0] cfg_max   = stpr_pkg::MAX_RATE_RST;
    logic [19:0] cfg_accel = stpr_pkg::ACCEL_STEP_RST;

    // predictor copy of the motion state
    logic [30:0] m_pos      = '0;
    logic [30:0] m_tgt      = '0;
    logic        m_dir      = 1'b0;
    logic [19:0] m_rate     = '0;
    logic [30:0] m_acc_left = '0;
    logic [30:0] m_dec_left = '0;
    logic        m_run      = 1'b0;

    ramp_report_t ramp_reports_q[$];

    int send_gap_pct = 21;
    int recv_gap_pct = 70;

    int err_count = 0;
    int results_checked = 0;
    int reloads_seen = 0;
    int stops_seen = 0;
    int cmds_sent = 0;
    int work_items = 0;
    int moves_sent = 0;
    int ticks_sent = 0;
    int sets_sent = 0;
    int unused_sent = 0;
    int settings_used = 0;
    int stall_cycles = 0;

    // ramp length for the current registers
    function automatic longint unsigned ramp_len();
        if (cfg_accel != '0 && cfg_max > cfg_min)
            return longint'(cfg_max - cfg_min) / longint'(cfg_accel);
        return 0;
    endfunction

    // timer reload for the current rate
    function automatic logic [31:0] reload_for_rate();
        if (m_rate == '0)
            return '1;
        return cfg_hz / {12'd0, m_rate};
    endfunction

    // direction, start rate and the split into ramp up and ramp down counts
    function automatic void start_ramp();
        longint          diff;
        longint unsigned move_dist;
        longint unsigned rl;
        diff = longint'($signed(m_tgt)) - longint'($signed(m_pos));
        if (diff < 0)
        begin
            move_dist = longint'(-diff);
            m_dir = 1'b1;
        end
        else
        begin
            move_dist = diff;
            m_dir = 1'b0;
        end
        m_rate = cfg_min;
        rl = ramp_len();
        if (move_dist >= rl * 2)
        begin
            m_acc_left = 31'(move_dist - rl);
            m_dec_left = 31'(rl);
        end
        else
        begin
            m_acc_left = 31'(move_dist / 2);
            m_dec_left = 31'(move_dist / 2);
        end
    endfunction

    // next state and status beat for one command
    function automatic ramp_report_t ramp_predict(input logic [1:0] f, input logic [30:0] v);
        ramp_report_t    rep;
        longint unsigned nxt;
        rep = '0;
        case (f)
            stpr_pkg::FUNC_MOVE:
            begin
                if (v != m_pos)
                begin
                    m_tgt = v;
                    start_ramp();
                    m_run = 1'b1;
                end
            end
            stpr_pkg::FUNC_TICK:
            begin
                if (m_run)
                begin
                    m_pos = m_dir ? m_pos - 31'd1 : m_pos + 31'd1;
                    if (m_pos == m_tgt)
                    begin
                        m_run = 1'b0;
                        rep.stopped = 1'b1;
                    end
                    if (m_acc_left != '0)
                    begin
                        nxt = longint'(m_rate) + longint'(cfg_accel);
                        if (nxt > longint'(cfg_max))
                            nxt = longint'(cfg_max);
                        m_rate = 20'(nxt);
                        rep.reload = reload_for_rate();
                        rep.written = 1'b1;
                        m_acc_left = m_acc_left - 31'd1;
                    end
                    else if (m_dec_left != '0)
                    begin
                        // saturate at the start rate instead of wrapping
                        if (longint'(m_rate) < longint'(cfg_min) + longint'(cfg_accel))
                            m_rate = cfg_min;
                        else
                            m_rate = m_rate - cfg_accel;
                        rep.reload = reload_for_rate();
                        rep.written = 1'b1;
                        m_dec_left = m_dec_left - 31'd1;
                    end
                    else
                    begin
                        m_run = 1'b0;
                        rep.stopped = 1'b1;
                    end
                end
            end
            stpr_pkg::FUNC_SET:
            begin
                m_pos = v;
            end
            default:
            begin
            end
        endcase
        rep.reverse = m_dir;
        rep.running = m_run;
        rep.pos = m_pos;
        return rep;
    endfunction

    task automatic set_idling(input int snd, input int rcv);
        send_gap_pct = snd;
        recv_gap_pct = rcv;
    endtask

    // one command beat, with random gaps before it
    task automatic send_cmd(input logic [1:0] f, input logic [30:0] v);
        while ($urandom_range(99) < send_gap_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.func <= f;
        cmd_ch.value <= v;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        cmds_sent++;
        if (!(f == FUNC_UNUSED || (f == stpr_pkg::FUNC_TICK && !m_run)))
            work_items++;
        case (f)
            stpr_pkg::FUNC_MOVE: moves_sent++;
            stpr_pkg::FUNC_TICK: ticks_sent++;
            stpr_pkg::FUNC_SET:  sets_sent++;
            default:             unused_sent++;
        endcase
        ramp_reports_q.push_back(ramp_predict(f, v));
    endtask

    // stop sending and let every status beat come back
    task automatic drain_status();
        cmd_ch.valid <= 1'b0;
        while (ramp_reports_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input stpr_pkg::cfg_idx_t idx, input logic [31:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= d;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            stpr_pkg::REG_CLOCK_HZ:   cfg_hz = d;
            stpr_pkg::REG_MIN_RATE:   cfg_min = d[19:0];
            stpr_pkg::REG_MAX_RATE:   cfg_max = d[19:0];
            stpr_pkg::REG_ACCEL_STEP: cfg_accel = d[19:0];
            default:                  ;
        endcase
    endtask

    // all four registers while idle; rate registers get junk in the unused bits
    task automatic write_regs(input logic [31:0] hz, input logic [19:0] mn,
                              input logic [19:0] mx, input logic [19:0] ac);
        drain_status();
        write_reg(stpr_pkg::REG_CLOCK_HZ, hz);
        write_reg(stpr_pkg::REG_MIN_RATE, {12'($urandom), mn});
        write_reg(stpr_pkg::REG_MAX_RATE, {12'($urandom), mx});
        write_reg(stpr_pkg::REG_ACCEL_STEP, {12'($urandom), ac});
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // position override during a move, often next to the target or a range end
    function automatic logic [30:0] mid_run_position();
        case ($urandom_range(3))
            0: return m_dir ? POS_MIN + 31'($urandom_range(2)) : POS_MAX - 31'($urandom_range(2));
            1: return m_dir ? m_tgt + 31'd1 : m_tgt - 31'd1;
            2: return 31'($urandom);
            default: return m_pos + 31'($urandom_range(6)) - 31'd3;
        endcase
    endfunction

    // move sequences with random content, plus some noise beats
    task automatic run_moves(input int n);
        int          stop_at;
        int          ticks;
        int          span;
        int          pick;
        longint      rl;
        logic [30:0] tgt;
        stop_at = work_items + n;
        while (work_items < stop_at)
        begin
            if ($urandom_range(99) < 75)
            begin
                rl = longint'(ramp_len());
                span = (rl >= 56) ? 120 : 2 * int'(rl) + 8;
                pick = $urandom_range(99);
                if (pick < 5)
                    tgt = m_pos;
                else if (pick < 15)
                    tgt = 31'($urandom);
                else if (pick < 57)
                    tgt = m_pos + 31'($urandom_range(1, span));
                else
                    tgt = m_pos - 31'($urandom_range(1, span));
                send_cmd(stpr_pkg::FUNC_MOVE, tgt);
                ticks = 0;
                while (m_run && ticks < 150 && work_items < stop_at)
                begin
                    pick = $urandom_range(99);
                    if (pick < 3)
                        send_cmd(stpr_pkg::FUNC_SET, mid_run_position());
                    else if (pick < 5)
                        send_cmd(stpr_pkg::FUNC_MOVE,
                                 m_pos + 31'($urandom_range(span)) - 31'(span / 2));
                    else
                        send_cmd(stpr_pkg::FUNC_TICK, 31'($urandom));
                    ticks++;
                end
                if ($urandom_range(3) == 0)
                    send_cmd(stpr_pkg::FUNC_TICK, 31'($urandom));
            end
            else
            begin
                if ($urandom_range(1) == 0)
                    send_cmd(2'($urandom_range(3)), 31'($urandom));
                else
                    send_cmd(2'($urandom_range(3)), m_pos + 31'($urandom_range(8)) - 31'd4);
            end
        end
    endtask

    // reset values, every command and the corner cases of a move
    task automatic test_directed();
        send_cmd(stpr_pkg::FUNC_TICK, 31'($urandom));
        send_cmd(FUNC_UNUSED, 31'($urandom));
        send_cmd(stpr_pkg::FUNC_MOVE, 31'd0);
        // short move split in half, then a tick after the stop
        send_cmd(stpr_pkg::FUNC_MOVE, 31'd3);
        repeat (4) send_cmd(stpr_pkg::FUNC_TICK, 31'($urandom));
        // reverse move wrapping past the lowest position, ends on exhausted counts
        send_cmd(stpr_pkg::FUNC_MOVE, -31'sd2);
        send_cmd(stpr_pkg::FUNC_TICK, 31'd0);
        send_cmd(stpr_pkg::FUNC_SET, POS_MIN);
        repeat (4) send_cmd(stpr_pkg::FUNC_TICK, POS_MAX);
        // target hit while counts remain
        send_cmd(stpr_pkg::FUNC_SET, 31'd0);
        send_cmd(stpr_pkg::FUNC_MOVE, 31'd40);
        send_cmd(stpr_pkg::FUNC_SET, 31'd38);
        repeat (2) send_cmd(stpr_pkg::FUNC_TICK, 31'd0);
        // range extremes, rebuild while running, move to the current spot while running
        send_cmd(stpr_pkg::FUNC_MOVE, POS_MAX);
        send_cmd(stpr_pkg::FUNC_TICK, 31'd0);
        send_cmd(stpr_pkg::FUNC_MOVE, POS_MIN);
        send_cmd(stpr_pkg::FUNC_TICK, 31'd0);
        send_cmd(stpr_pkg::FUNC_MOVE, m_pos);
        send_cmd(stpr_pkg::FUNC_TICK, 31'd0);
    endtask

    // register extremes: empty ramps, zero rates, zero clock, max below min
    task automatic test_register_extremes();
        write_regs(32'd1000000, 20'd100, 20'd160, 20'd20);
        run_moves(55);
        write_regs(32'hFFFF_FFFF, 20'd1, 20'hFFFFF, 20'd1);
        run_moves(55);
        write_regs(32'hFFFF_FFFF, 20'd1, 20'hFFFFF, 20'hFFFFF);
        run_moves(55);
        write_regs(32'd1, 20'hFFFFF, 20'hFFFFF, 20'd5);
        run_moves(55);
        write_regs(32'd0, 20'd50, 20'd90, 20'd10);
        run_moves(55);
        write_regs(32'd5000, 20'd0, 20'd3, 20'd1);
        run_moves(55);
        write_regs(32'd7777, 20'd0, 20'd0, 20'd4);
        run_moves(55);
        write_regs(32'd100000, 20'd400, 20'd60, 20'd7);
        run_moves(55);
        write_regs(32'd123456, 20'd200, 20'd260, 20'd0);
        run_moves(55);
    endtask

    // random register settings, mostly with short ramps
    task automatic test_random_profiles(input int n_settings, input int n_items);
        logic [31:0]     hz;
        logic [19:0]     mn;
        logic [19:0]     ac;
        longint unsigned mx;
        repeat (n_settings)
        begin
            hz = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1000, 50000000);
            mn = ($urandom_range(7) == 0) ? 20'($urandom) : 20'($urandom_range(1, 5000));
            ac = ($urandom_range(7) == 0) ? 20'($urandom) : 20'($urandom_range(1, 400));
            mx = longint'(mn) + longint'(ac) * $urandom_range(12) + $urandom_range(ac);
            if ($urandom_range(7) == 0)
                mx = longint'(20'($urandom));
            if (mx > 20'hFFFFF)
                mx = longint'(20'hFFFFF);
            write_regs(hz, mn, 20'(mx), ac);
            run_moves(n_items);
        end
    endtask

    // receiver stalls
    always @(posedge clk)
        res_ch.ready <= ($urandom_range(99) >= recv_gap_pct);

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            err_count++;
            if (err_count <= SHOWN_ERRORS)
                $display("mismatch in %s of status beat %0d: expected %h, got %h",
                         name, results_checked, want, got);
        end
    endfunction

    // status beat check against the oldest prediction
    always @(posedge clk)
    begin
        ramp_report_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (ramp_reports_q.size() == 0)
            begin
                err_count++;
                if (err_count <= SHOWN_ERRORS)
                    $display("status beat with nothing expected, position %h",
                             res_ch.position);
            end
            else
            begin
                want = ramp_reports_q.pop_front();
                compare_field("reload_value", want.reload, res_ch.reload_value);
                compare_field("reload_written", 32'(want.written), 32'(res_ch.reload_written));
                compare_field("direction_reverse", 32'(want.reverse),
                              32'(res_ch.direction_reverse));
                compare_field("running", 32'(want.running), 32'(res_ch.running));
                compare_field("stopped_now", 32'(want.stopped), 32'(res_ch.stopped_now));
                compare_field("position", {1'b0, want.pos}, {1'b0, res_ch.position});
                if (want.written)
                    reloads_seen++;
                if (want.stopped)
                    stops_seen++;
            end
            results_checked++;
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("no beat for %0d cycles", stall_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int waited;
        cmd_ch.valid <= 1'b0;
        cmd_ch.func <= stpr_pkg::FUNC_MOVE;
        cmd_ch.value <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= stpr_pkg::REG_CLOCK_HZ;
        cfg_ch.data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        set_idling(21, 70);
        test_directed();
        test_register_extremes();
        set_idling(70, 21);
        test_random_profiles(6, 90);
        set_idling(0, 0);
        test_random_profiles(6, 85);

        // wind down
        cmd_ch.valid <= 1'b0;
        waited = 0;
        while (ramp_reports_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (ramp_reports_q.size() != 0)
        begin
            err_count += ramp_reports_q.size();
            $display("%0d status beats never arrived", ramp_reports_q.size());
        end

        $display("sent %0d commands (%0d moves, %0d ticks, %0d sets, %0d unused) over %0d settings",
                 cmds_sent, moves_sent, ticks_sent, sets_sent, unused_sent, settings_used + 1);
        $display("checked %0d status beats: %0d reload updates, %0d stops, %0d mismatches",
                 results_checked, reloads_seen, stops_seen, err_count);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
